/* design/ltws_pkg.sv */
// ----------------------------------------------------------------------------
// ltws_pkg
// Shared types, codes and character-class lookup for the line tokenizer.
// ----------------------------------------------------------------------------
package ltws_pkg;

    typedef logic [2:0] mode_t;
    typedef logic [1:0] action_t;
    typedef logic [4:0] cls_t;

    localparam mode_t MODE_BETWEEN   = 3'd0;
    localparam mode_t MODE_TOKEN     = 3'd1;
    localparam mode_t MODE_STRING    = 3'd2;
    localparam mode_t MODE_STRING_BS = 3'd3;
    localparam mode_t MODE_COMMENT   = 3'd4;

    localparam action_t ACT_NONE   = 2'd0;
    localparam action_t ACT_BEGIN  = 2'd1;
    localparam action_t ACT_APPEND = 2'd2;

    localparam cls_t CL_SPACE    = 5'b00001;
    localparam cls_t CL_IDFIRST  = 5'b00010;
    localparam cls_t CL_IDREST   = 5'b00100;
    localparam cls_t CL_NUMFIRST = 5'b01000;
    localparam cls_t CL_OTHER    = 5'b10000;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    function automatic cls_t char_class(input logic [7:0] c);
        cls_t r;
        r = '0;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
        begin
            r = CL_IDFIRST | CL_IDREST;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = CL_IDREST | CL_NUMFIRST;
        end
        else
        begin
            unique case (c)
                8'h5F, 8'h25, 8'h24:
                    r = CL_IDFIRST | CL_IDREST;
                8'h3A, 8'h2F, 8'h3C, 8'h3E, 8'h2C, 8'h40:
                    r = CL_IDREST;
                8'h2D, 8'h2E, 8'h2B:
                    r = CL_NUMFIRST;
                8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0C, 8'h3D, 8'h00:
                    r = CL_SPACE;
                8'h23, 8'h5B, 8'h5D, 8'h22:
                    r = CL_OTHER;
                default:
                    r = '0;
            endcase
        end
        return r;
    endfunction

endpackage

/* design/line_tokenizer_with_strings_unit.sv */
// ----------------------------------------------------------------------------
// line_tokenizer_with_strings_unit
// Byte-wise line tokenizer: marks token starts and continuations and judges
// each line at its last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one byte of a text line per
//   beat, text_byte plus line_last on the final byte of the line.
//   Output channel (out_valid / out_stall) returns one beat per input beat:
//   token_action (none / begin / append), and on the last byte line_done
//   with line_ok telling whether the line was accepted.
//   A beat accepted into the input register moves on to the result register
//   as soon as that register is free; out_valid is high from then until the
//   result is taken.
//   Throughput: one byte per cycle while the output does not stall; the input
//   register and the result register form a two-entry pipe, and the tokenizer
//   state (mode, list flag, failure flag) updates as a beat moves between them.
//   A stall on the output holds the result register; the input register
//   still takes one more beat, after which in_stall rises.
//   Reset empties both registers and puts the scan between tokens, outside
//   any list, with no failure recorded. Each line's last byte returns the
//   state to that same condition.
// ----------------------------------------------------------------------------
module line_tokenizer_with_strings_unit
    import ltws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       line_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] token_action,
    output logic       line_done,
    output logic       line_ok
);

    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;

    mode_t      mode_reg, mode_next;
    logic       list_reg, list_next;
    logic       failed_reg, failed_next;

    logic       b_valid_reg;
    action_t    b_action_reg;
    logic       b_done_reg;
    logic       b_ok_reg;

    action_t    action_next;
    logic       ok_next;
    cls_t       cls;
    logic       between;
    logic       b_free;
    logic       b_load;
    logic       a_load;

    assign b_free   = !b_valid_reg || !out_stall;
    assign b_load   = a_valid_reg && b_free;
    assign in_stall = a_valid_reg && !b_free;
    assign a_load   = in_valid && !in_stall;

    assign cls     = char_class(a_byte_reg);
    assign between = (mode_reg != MODE_TOKEN);

    always_comb
    begin
        mode_next   = mode_reg;
        list_next   = list_reg;
        failed_next = failed_reg;
        action_next = ACT_NONE;
        if (!failed_reg)
        begin
            priority case (mode_reg)
                MODE_COMMENT:
                begin
                    action_next = ACT_APPEND;
                end
                MODE_STRING:
                begin
                    action_next = ACT_APPEND;
                    if (a_byte_reg == CH_QUOTE)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                    else if (a_byte_reg == CH_BSLASH)
                    begin
                        mode_next = MODE_STRING_BS;
                    end
                end
                MODE_STRING_BS:
                begin
                    action_next = ACT_APPEND;
                    mode_next   = MODE_STRING;
                end
                default:
                begin
                    priority if (cls == '0)
                    begin
                        failed_next = 1'b1;
                    end
                    else if ((cls & CL_SPACE) != '0)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                    else if (between && ((cls & (CL_IDFIRST | CL_NUMFIRST)) == '0)
                             && ((cls & CL_IDREST) != '0))
                    begin
                        failed_next = 1'b1;
                    end
                    else if (a_byte_reg == CH_HASH)
                    begin
                        action_next = ACT_BEGIN;
                        mode_next   = MODE_COMMENT;
                    end
                    else if (a_byte_reg == CH_QUOTE)
                    begin
                        action_next = ACT_BEGIN;
                        mode_next   = MODE_STRING;
                    end
                    else if (a_byte_reg == CH_LBRACK)
                    begin
                        action_next = ACT_BEGIN;
                        failed_next = list_reg;
                        list_next   = 1'b1;
                        mode_next   = MODE_BETWEEN;
                    end
                    else if (a_byte_reg == CH_RBRACK)
                    begin
                        action_next = ACT_BEGIN;
                        failed_next = !list_reg;
                        list_next   = 1'b0;
                        mode_next   = MODE_BETWEEN;
                    end
                    else
                    begin
                        action_next = between ? ACT_BEGIN : ACT_APPEND;
                        mode_next   = MODE_TOKEN;
                    end
                end
            endcase
        end
        ok_next = !failed_next && !list_next && (mode_next != MODE_STRING)
                  && (mode_next != MODE_STRING_BS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            mode_reg    <= MODE_BETWEEN;
            list_reg    <= 1'b0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_load)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_load)
            begin
                if (a_last_reg)
                begin
                    mode_reg   <= MODE_BETWEEN;
                    list_reg   <= 1'b0;
                    failed_reg <= 1'b0;
                end
                else
                begin
                    mode_reg   <= mode_next;
                    list_reg   <= list_next;
                    failed_reg <= failed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_byte_reg <= text_byte;
            a_last_reg <= line_last;
        end
        if (b_load)
        begin
            b_action_reg <= action_next;
            b_done_reg   <= a_last_reg;
            b_ok_reg     <= a_last_reg && ok_next;
        end
    end

    assign out_valid    = b_valid_reg;
    assign token_action = b_action_reg;
    assign line_done    = b_done_reg;
    assign line_ok      = b_ok_reg;

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_ok |-> line_done)
        else $error("line_ok without line_done");

    a_action_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_action == ACT_NONE || token_action == ACT_BEGIN
                       || token_action == ACT_APPEND))
        else $error("token_action out of range");

    a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
        b_load && a_last_reg |=> (mode_reg == MODE_BETWEEN) && !list_reg && !failed_reg)
        else $error("state not cleared after end of line");

    a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        b_load && failed_reg |=> out_valid && (token_action == ACT_NONE) && !line_ok)
        else $error("failed line produced a token or an accept");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg && b_valid_reg && out_stall)
        else $error("input stalled with room in the pipe");

endmodule

/* dv/line_tokenizer_with_strings_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_tokenizer_with_strings_unit_tb
// Self-checking bench for the byte-wise line tokenizer. A short table of
// directed lines (byte extremes, every token kind, rejected lines) is sent
// first. Random lines follow, mostly well formed with random content, the
// rest noise or damaged lines. Untyped beats are predicted by a local model of
// the scan state. Each result beat is compared field by field in order.
// Sender bursts and receiver stalls are random, with one long output
// hold-off that backs the pipe up into the input.
// ----------------------------------------------------------------------------
module line_tokenizer_with_strings_unit_tb;
    import ltws_pkg::*;

    typedef struct packed {
        action_t action;
        logic    done;
        logic    ok;
    } tok_result_t;

    typedef struct packed {
        logic space;
        logic id_head;
        logic id_tail;
        logic num_head;
        logic punct;
    } byte_kind_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        tok_result_t want;
    } dir_row_t;

    localparam tok_result_t WANT_ANY = '0;
    localparam int DIR_ROWS = 26;
    localparam int RANDOM_BYTES = 550;

    localparam string ID_HEAD =
        "_%$abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string ID_TAIL =
        "_%$:/<>,@0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string NUM_HEAD = "0123456789-.+";
    localparam string NUM_TAIL = "0123456789.";
    localparam string SPACES   = " \011\015\012\014=";

    // typed rows carry the expected beat; the rest go to the predictor
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'hFF,     1'b1, 1'b1, '{ACT_NONE,   1'b1, 1'b0}},
        '{8'h00,     1'b1, 1'b1, '{ACT_NONE,   1'b1, 1'b1}},
        '{"a",       1'b0, 1'b0, WANT_ANY},
        '{"9",       1'b0, 1'b0, WANT_ANY},
        '{":",       1'b0, 1'b0, WANT_ANY},
        '{" ",       1'b0, 1'b0, WANT_ANY},
        '{"-",       1'b0, 1'b0, WANT_ANY},
        '{CH_LBRACK, 1'b0, 1'b0, WANT_ANY},
        '{"x",       1'b0, 1'b0, WANT_ANY},
        '{CH_RBRACK, 1'b0, 1'b0, WANT_ANY},
        '{CH_HASH,   1'b0, 1'b0, WANT_ANY},
        '{8'h7E,     1'b1, 1'b0, WANT_ANY},
        '{CH_QUOTE,  1'b0, 1'b0, WANT_ANY},
        '{CH_BSLASH, 1'b0, 1'b0, WANT_ANY},
        '{CH_QUOTE,  1'b0, 1'b0, WANT_ANY},
        '{"q",       1'b1, 1'b1, '{ACT_APPEND, 1'b1, 1'b0}},
        '{",",       1'b1, 1'b1, '{ACT_NONE,   1'b1, 1'b0}},
        '{CH_LBRACK, 1'b0, 1'b0, WANT_ANY},
        '{CH_LBRACK, 1'b1, 1'b1, '{ACT_BEGIN,  1'b1, 1'b0}},
        '{CH_RBRACK, 1'b1, 1'b1, '{ACT_BEGIN,  1'b1, 1'b0}},
        '{CH_LBRACK, 1'b1, 1'b1, '{ACT_BEGIN,  1'b1, 1'b0}},
        '{"x",       1'b0, 1'b0, WANT_ANY},
        '{8'h01,     1'b0, 1'b0, WANT_ANY},
        '{"y",       1'b1, 1'b1, '{ACT_NONE,   1'b1, 1'b0}},
        '{CH_QUOTE,  1'b0, 1'b0, WANT_ANY},
        '{CH_BSLASH, 1'b1, 1'b1, '{ACT_APPEND, 1'b1, 1'b0}}
    };

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] text_byte  = 8'h00;
    logic       line_last  = 1'b0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] token_action;
    logic       line_done;
    logic       line_ok;

    mode_t tok_mode  = MODE_BETWEEN;
    logic  list_open = 1'b0;
    logic  line_bad  = 1'b0;

    tok_result_t byte_verdicts [$];
    int burst_left   = 0;
    int errors       = 0;
    int bytes_sent   = 0;
    int lines_good   = 0;
    int lines_reject = 0;
    int token_starts = 0;

    line_tokenizer_with_strings_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .line_last    (line_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_action (token_action),
        .line_done    (line_done),
        .line_ok      (line_ok)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic byte_kind_t classify(input logic [7:0] c);
        byte_kind_t k;
        logic [7:0] folded;
        k = '0;
        folded = c | 8'h20;
        if (folded >= "a" && folded <= "z" && (c & 8'h80) == 8'h00)
        begin
            k.id_head = 1'b1;
            k.id_tail = 1'b1;
        end
        else if (c >= "0" && c <= "9")
        begin
            k.id_tail  = 1'b1;
            k.num_head = 1'b1;
        end
        else
        begin
            case (c)
                "_", "%", "$":
                begin
                    k.id_head = 1'b1;
                    k.id_tail = 1'b1;
                end
                ":", "/", "<", ">", ",", "@":
                    k.id_tail = 1'b1;
                "-", ".", "+":
                    k.num_head = 1'b1;
                " ", "=", 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h00:
                    k.space = 1'b1;
                CH_HASH, CH_LBRACK, CH_RBRACK, CH_QUOTE:
                    k.punct = 1'b1;
                default:
                    k = '0;
            endcase
        end
        return k;
    endfunction

    function automatic tok_result_t tokenize_byte(input logic [7:0] c, input logic fin);
        tok_result_t r;
        byte_kind_t  k;
        logic        outside;
        r = '0;
        r.action = ACT_NONE;
        k = classify(c);
        outside = (tok_mode != MODE_TOKEN);
        if (!line_bad)
        begin
            case (tok_mode)
                MODE_COMMENT:
                    r.action = ACT_APPEND;
                MODE_STRING:
                begin
                    r.action = ACT_APPEND;
                    if (c == CH_QUOTE)
                        tok_mode = MODE_BETWEEN;
                    else if (c == CH_BSLASH)
                        tok_mode = MODE_STRING_BS;
                end
                MODE_STRING_BS:
                begin
                    r.action = ACT_APPEND;
                    tok_mode = MODE_STRING;
                end
                default:
                begin
                    if (k == '0)
                        line_bad = 1'b1;
                    else if (k.space)
                        tok_mode = MODE_BETWEEN;
                    else if (outside && k.id_tail && !k.id_head && !k.num_head)
                        line_bad = 1'b1;
                    else if (c == CH_HASH)
                    begin
                        r.action = ACT_BEGIN;
                        tok_mode = MODE_COMMENT;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        r.action = ACT_BEGIN;
                        tok_mode = MODE_STRING;
                    end
                    else if (c == CH_LBRACK)
                    begin
                        r.action = ACT_BEGIN;
                        if (list_open)
                            line_bad = 1'b1;
                        list_open = 1'b1;
                        tok_mode = MODE_BETWEEN;
                    end
                    else if (c == CH_RBRACK)
                    begin
                        r.action = ACT_BEGIN;
                        if (!list_open)
                            line_bad = 1'b1;
                        list_open = 1'b0;
                        tok_mode = MODE_BETWEEN;
                    end
                    else
                    begin
                        r.action = outside ? ACT_BEGIN : ACT_APPEND;
                        tok_mode = MODE_TOKEN;
                    end
                end
            endcase
        end
        if (fin)
        begin
            r.done = 1'b1;
            r.ok = !line_bad && !list_open && tok_mode != MODE_STRING &&
                   tok_mode != MODE_STRING_BS;
            tok_mode  = MODE_BETWEEN;
            list_open = 1'b0;
            line_bad  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_space();
        if ($urandom_range(0, 7) == 0)
            return 8'h00;
        return pick_from(SPACES);
    endfunction

    task automatic add_word(ref logic [7:0] q [$]);
        q.push_back(pick_from(ID_HEAD));
        repeat ($urandom_range(0, 5))
            q.push_back(pick_from(ID_TAIL));
    endtask

    // called at the edge that took the previous beat
    task automatic pace();
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    task automatic send_beat(input logic [7:0] c, input logic fin,
                             input logic typed, input tok_result_t want);
        tok_result_t r;
        in_valid  <= 1'b1;
        text_byte <= c;
        line_last <= fin;
        do
            @(posedge clk);
        while (in_stall);
        r = tokenize_byte(c, fin);
        if (typed)
            r = want;
        byte_verdicts.push_back(r);
        bytes_sent++;
    endtask

    initial
    begin : stimulus
        logic [7:0] line_q [$];
        logic [7:0] b;
        int         line_kind;
        int         random_sent;
        random_sent = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i > 0)
                pace();
            send_beat(DIR_TABLE[i].ch, DIR_TABLE[i].fin, DIR_TABLE[i].typed,
                      DIR_TABLE[i].want);
        end

        while (random_sent < RANDOM_BYTES)
        begin
            line_q.delete();
            line_kind = $urandom_range(0, 99);
            if (line_kind < 15)
            begin
                repeat ($urandom_range(1, 8))
                    line_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                for (int t = 0; t < $urandom_range(1, 4); t++)
                begin
                    if (t > 0 || $urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2))
                            line_q.push_back(pick_space());
                    case ($urandom_range(0, 3))
                        0:
                            add_word(line_q);
                        1:
                        begin
                            line_q.push_back(pick_from(NUM_HEAD));
                            repeat ($urandom_range(0, 4))
                                line_q.push_back(pick_from(NUM_TAIL));
                        end
                        2:
                        begin
                            line_q.push_back(CH_QUOTE);
                            repeat ($urandom_range(0, 6))
                            begin
                                if ($urandom_range(0, 5) == 0)
                                begin
                                    line_q.push_back(CH_BSLASH);
                                    line_q.push_back(8'($urandom_range(0, 255)));
                                end
                                else
                                begin
                                    b = 8'($urandom_range(1, 255));
                                    if (b == CH_QUOTE || b == CH_BSLASH)
                                        b = "s";
                                    line_q.push_back(b);
                                end
                            end
                            line_q.push_back(CH_QUOTE);
                        end
                        default:
                        begin
                            line_q.push_back(CH_LBRACK);
                            add_word(line_q);
                            if ($urandom_range(0, 1) == 0)
                                line_q.push_back(pick_space());
                            line_q.push_back(CH_RBRACK);
                        end
                    endcase
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    line_q.push_back(pick_space());
                    line_q.push_back(CH_HASH);
                    repeat ($urandom_range(0, 6))
                        line_q.push_back(8'($urandom_range(0, 255)));
                end
                // damaged lines: corrupt, cut short or add a stray bracket
                if (line_kind >= 85)
                begin
                    case ($urandom_range(0, 2))
                        0:
                            line_q[$urandom_range(0, line_q.size() - 1)] =
                                8'($urandom_range(0, 255));
                        1:
                            line_q = line_q[0:$urandom_range(0, line_q.size() - 1)];
                        default:
                            line_q.insert($urandom_range(0, line_q.size()),
                                ($urandom_range(0, 1) == 0) ? CH_LBRACK : CH_RBRACK);
                    endcase
                end
            end
            foreach (line_q[j])
            begin
                pace();
                send_beat(line_q[j], j == line_q.size() - 1, 1'b0, WANT_ANY);
                random_sent++;
            end
        end

        in_valid <= 1'b0;
        while (byte_verdicts.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);

        $display("Sent %0d bytes: %0d lines accepted, %0d rejected, %0d token starts.",
                 bytes_sent, lines_good, lines_reject, token_starts);
        if (errors == 0 && byte_verdicts.size() == 0)
            $display("line_tokenizer_with_strings_unit_tb passed");
        else
            $display("line_tokenizer_with_strings_unit_tb failed");
        $finish;
    end

    initial
    begin : receiver
        int stall_pct;
        @(posedge rst_n);
        repeat (40)
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(0, 99) < 30);
        end
        // long hold-off: the pipe fills and in_stall must rise
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (60)
            @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 20;
                3:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat ($urandom_range(16, 64))
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        tok_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (byte_verdicts.size() == 0)
            begin
                $error("result beat with no byte pending");
                errors++;
            end
            else
            begin
                want = byte_verdicts.pop_front();
                if (token_action !== want.action)
                begin
                    $error("token_action: expected %0d, got %0d", want.action, token_action);
                    errors++;
                end
                if (line_done !== want.done)
                begin
                    $error("line_done: expected %0d, got %0d", want.done, line_done);
                    errors++;
                end
                if (line_ok !== want.ok)
                begin
                    $error("line_ok: expected %0d, got %0d", want.ok, line_ok);
                    errors++;
                end
                if (want.done && want.ok)
                    lines_good++;
                else if (want.done)
                    lines_reject++;
                if (want.action == ACT_BEGIN)
                    token_starts++;
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("line_tokenizer_with_strings_unit_tb failed");
        $finish;
    end

endmodule
